// ----- rtl/fbpa_pkg.sv -----
// Package for the fixed block pool allocator.
// Holds port widths, reset defaults and the controller/datapath link types.
// No dependencies.
`timescale 1ns / 1ps

package fbpa_pkg;

  localparam int MAX_BLOCKS_DEFAULT = 4096;
  localparam int RESET_BLOCKS       = 4096;

  localparam int IDX_PORT_W  = 12;
  localparam int CNT_PORT_W  = 13;
  localparam int CFG_W       = 13;
  localparam int S_TDATA_W   = 16;
  localparam int M_TDATA_W   = 32;

  typedef struct packed {
    logic accept;
    logic commit;
  } fbpa_cmd_t;

  typedef struct packed {
    logic out_busy;
  } fbpa_status_t;

endpackage

// ----- rtl/fbpa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/fbpa_ctrl.sv -----
// Controller for the block pool allocator: accept / execute sequencing.
// Depends on fbpa_pkg.
`timescale 1ns / 1ps

module fbpa_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  fbpa_pkg::fbpa_status_t status,
  output fbpa_pkg::fbpa_cmd_t    cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;

  assign s_axis_tready = (state == ST_IDLE);
  assign cmd.accept    = s_axis_tvalid && (state == ST_IDLE);
  assign cmd.commit    = (state == ST_EXEC) && !status.out_busy;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cmd.commit) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/fbpa_datapath.sv -----
// Datapath for the block pool allocator: pool registers, link RAM, output register.
// Depends on fbpa_pkg and fbpa_ram.
`timescale 1ns / 1ps

module fbpa_datapath #(
  parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [fbpa_pkg::CFG_W-1:0]        cfg_wr_data,
  input  logic [fbpa_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  input  logic [0:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [fbpa_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  input  fbpa_pkg::fbpa_cmd_t               cmd,
  output fbpa_pkg::fbpa_status_t            status
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int CMP_W = (CNT_W > fbpa_pkg::IDX_PORT_W) ? CNT_W : fbpa_pkg::IDX_PORT_W;
  localparam int RESET_CNT =
    (fbpa_pkg::RESET_BLOCKS > MAX_BLOCKS) ? MAX_BLOCKS : fbpa_pkg::RESET_BLOCKS;

  logic [CNT_W-1:0] blocks_in_use;
  logic [IDX_W-1:0] head;
  logic [CNT_W-1:0] free_cnt;
  logic [CNT_W-1:0] init_cnt;

  logic                          req_q;
  logic [fbpa_pkg::IDX_PORT_W-1:0] idx_q;
  logic                          fwd_q;
  logic [CNT_W-1:0]              fwd_val;

  logic [IDX_W-1:0] head_next;
  logic [CNT_W-1:0] free_next;
  logic             ok_next;
  logic [IDX_W-1:0] granted_next;

  logic             lazy;
  logic [CNT_W-1:0] lazy_val;
  logic [CMP_W-1:0] idx_ext;
  logic             free_ok;
  logic [CNT_W-1:0] nxt;
  logic [CNT_W-1:0] cfg_blocks;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [CNT_W-1:0] ram_wdata;
  logic [CNT_W-1:0] ram_rdata;

  // Clamp written block count to 1 .. MAX_BLOCKS
  always_comb begin
    if (cfg_wr_data == '0) begin
      cfg_blocks = CNT_W'(1);
    end else if (32'(cfg_wr_data) > 32'(MAX_BLOCKS)) begin
      cfg_blocks = CNT_W'(MAX_BLOCKS);
    end else begin
      cfg_blocks = CNT_W'(cfg_wr_data);
    end
  end

  assign lazy     = !s_axis_tuser[0] && (init_cnt < blocks_in_use);
  assign lazy_val = init_cnt + CNT_W'(1);
  assign idx_ext  = CMP_W'(idx_q);
  assign free_ok  = (idx_ext < CMP_W'(blocks_in_use)) && (free_cnt < blocks_in_use);
  assign nxt      = fwd_q ? fwd_val : ram_rdata;

  // Lazy link init at accept; free pushes its link at commit
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = init_cnt[IDX_W-1:0];
    ram_wdata = lazy_val;
    if (cmd.accept && lazy) begin
      ram_we = 1'b1;
    end else if (cmd.commit && req_q && free_ok) begin
      ram_we    = 1'b1;
      ram_waddr = idx_ext[IDX_W-1:0];
      ram_wdata = (free_cnt != '0) ? CNT_W'(head) : blocks_in_use;
    end
  end

  fbpa_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.accept),
    .raddr (head),
    .rdata (ram_rdata)
  );

  always_comb begin
    head_next    = head;
    free_next    = free_cnt;
    ok_next      = 1'b0;
    granted_next = '0;
    if (!req_q) begin
      if (free_cnt != '0) begin
        ok_next      = 1'b1;
        granted_next = head;
        free_next    = free_cnt - CNT_W'(1);
        if (free_next != '0) begin
          head_next = (nxt < blocks_in_use) ? nxt[IDX_W-1:0] : '0;
        end else begin
          head_next = '0;
        end
      end
    end else if (free_ok) begin
      ok_next   = 1'b1;
      head_next = idx_ext[IDX_W-1:0];
      free_next = free_cnt + CNT_W'(1);
    end
  end

  assign status.out_busy = m_axis_tvalid && !m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_in_use <= CNT_W'(RESET_CNT);
      head          <= '0;
      free_cnt      <= CNT_W'(RESET_CNT);
      init_cnt      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        blocks_in_use <= cfg_blocks;
        head          <= '0;
        free_cnt      <= cfg_blocks;
        init_cnt      <= '0;
      end else begin
        if (cmd.accept && lazy) begin
          init_cnt <= lazy_val;
        end
        if (cmd.commit) begin
          head     <= head_next;
          free_cnt <= free_next;
        end
      end
      if (cmd.commit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_q   <= s_axis_tuser[0];
      idx_q   <= s_axis_tdata[fbpa_pkg::IDX_PORT_W-1:0];
      fwd_q   <= lazy && (CNT_W'(head) == init_cnt);
      fwd_val <= lazy_val;
    end
    if (cmd.commit) begin
      m_axis_tdata <= fbpa_pkg::M_TDATA_W'({fbpa_pkg::CNT_PORT_W'(free_next),
                        fbpa_pkg::IDX_PORT_W'(granted_next), ok_next});
    end
  end

endmodule

// ----- rtl/fixed_block_pool_allocator.sv -----
// Fixed block pool allocator, top level: index-based free list built lazily.
// Result: registered in the output register when the execute state commits; commit waits while the output stalls.
// A new item is taken only once the previous one commits, set by the registered read of the link RAM.
// The next item is taken while the previous result still waits in the output register.
// Reset: synchronous; pool restarts with 4096 blocks (or MAX_BLOCKS) all free, head 0.
// Depends on fbpa_pkg, fbpa_ctrl, fbpa_datapath, fbpa_ram.
`timescale 1ns / 1ps

module fixed_block_pool_allocator #(
  parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [fbpa_pkg::CFG_W-1:0]     cfg_wr_data,   // blocks_in_use
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [fbpa_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [11:0] freed_index
  input  logic [0:0]                     s_axis_tuser,  // [0] req_type
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [fbpa_pkg::M_TDATA_W-1:0] m_axis_tdata   // [0] ok, [12:1] granted_index,
                                                        // [25:13] free_count
);

  fbpa_pkg::fbpa_cmd_t    cmd;
  fbpa_pkg::fbpa_status_t status;

  fbpa_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status        (status),
    .cmd           (cmd)
  );

  fbpa_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cmd           (cmd),
    .status        (status)
  );

endmodule

// ----- rtl/fbpa_checker.sv -----
// Port-level checker for the block pool allocator, bound to the top level.
// Depends on fbpa_pkg.
`timescale 1ns / 1ps

module fbpa_checker #(
  parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEFAULT
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [fbpa_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  // One item at a time: input closes after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an item is in flight");

  // Refused or empty requests grant nothing
  a_no_grant_on_refuse: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[12:1] == '0))
    else $error("granted index set on a refused item");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (32'(m_axis_tdata[25:13]) <= 32'(MAX_BLOCKS)))
    else $error("free count above pool size");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind fixed_block_pool_allocator fbpa_checker #(
  .MAX_BLOCKS (MAX_BLOCKS)
) u_fbpa_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
